FILE: rtl/tatd_pkg.sv
package tatd_pkg;

  // Algorithm settings
  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int ATAN_TAB_LEN    = 24;
  localparam int CORDIC_ITERS    = (CORDIC_STEPS < ATAN_TAB_LEN) ? CORDIC_STEPS : ATAN_TAB_LEN;
  localparam int ACC_FRAC        = 16;   // angle accumulator: degrees * 2^16
  localparam int PRESCALE_SH     = 8;    // operands scaled by 256 before vectoring
  localparam int ROUND_SH        = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int ANGLE_LIM       = 90 << ANGLE_FRAC_BITS;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int HELD_W     = 19;
  localparam int ANGLE_W    = 15;
  localparam int AXIS_W     = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 15;

  // Datapath widths
  localparam int SQ_W       = 2 * HELD_W;  // full product of a held value squared
  localparam int RAD_W      = 36;          // sum of two squares stays below 2^35
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SQRT_CNT_W = $clog2(ROOT_W);
  localparam int CORD_W     = 30;          // vector components incl. CORDIC gain
  localparam int ACC_W      = 26;          // angle accumulator
  localparam int ATAN_W     = 22;
  localparam int STEP_W     = 5;

  // Reset values
  localparam logic signed [HELD_W-1:0]     HELD_Z_RESET = 19'sd163840;
  localparam logic signed [CFG_DATA_W-1:0] MIN_RESET    = -15'sd3840;
  localparam logic signed [CFG_DATA_W-1:0] MAX_RESET    = 15'sd3840;

  // Axis codes
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 8'd3;

  // atan(2^-i) in degrees * 65536, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/tatd_in_if.sv
interface tatd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tatd_pkg::SAMPLE_W-1:0] raw_sample;
  logic                                 read_ok;

  modport source (output valid, raw_sample, read_ok, input ready);
  modport sink   (input valid, raw_sample, read_ok, output ready);
endinterface

FILE: rtl/tatd_out_if.sv
interface tatd_out_if;
  logic                                valid;
  logic                                ready;
  logic        [tatd_pkg::AXIS_W-1:0]  axis;
  logic signed [tatd_pkg::HELD_W-1:0]  axis_value;
  logic signed [tatd_pkg::ANGLE_W-1:0] angle_x;
  logic signed [tatd_pkg::ANGLE_W-1:0] angle_y;
  logic                                tipped;

  modport source (output valid, axis, axis_value, angle_x, angle_y, tipped, input ready);
  modport sink   (input valid, axis, axis_value, angle_x, angle_y, tipped, output ready);
endinterface

FILE: rtl/tatd_cfg_if.sv
interface tatd_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic        [tatd_pkg::CFG_IDX_W-1:0]  index;
  logic signed [tatd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/tatd_sqrt.sv
module tatd_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tatd_pkg::RAD_W-1:0]    rad_i,
  output logic                          done_o,
  output logic [tatd_pkg::ROOT_W-1:0]   root_o
);

  localparam int RW = tatd_pkg::ROOT_W;
  localparam logic [tatd_pkg::SQRT_CNT_W-1:0] LAST = tatd_pkg::SQRT_CNT_W'(RW - 1);

  logic                           busy_q, done_q;
  logic [tatd_pkg::SQRT_CNT_W-1:0] cnt_q;
  logic [tatd_pkg::RAD_W-1:0]     rad_q;
  logic [RW+1:0]                  rem_q;
  logic [RW-1:0]                  root_q;

  logic [RW+1:0] cat, sub;
  logic [RW+2:0] trial;
  logic          bit_ok;

  // One result bit per step: bring down two radicand bits, try to subtract 4*root+1
  always_comb begin
    cat    = {rem_q[RW-1:0], rad_q[tatd_pkg::RAD_W-1 -: 2]};
    sub    = {root_q, 2'b01};
    trial  = {1'b0, cat} - {1'b0, sub};
    bit_ok = !trial[RW+2];
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[tatd_pkg::RAD_W-3:0], 2'b00};
      rem_q  <= bit_ok ? trial[RW+1:0] : cat;
      root_q <= {root_q[RW-2:0], bit_ok};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: rtl/tatd_cordic.sv
module tatd_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [tatd_pkg::SAMPLE_W-1:0] num_i,
  input  logic        [tatd_pkg::ROOT_W-1:0]   den_i,
  output logic                                done_o,
  output logic signed [tatd_pkg::ANGLE_W-1:0] angle_o
);

  localparam int CW = tatd_pkg::CORD_W;
  localparam int AW = tatd_pkg::ACC_W;
  localparam logic [tatd_pkg::STEP_W-1:0] LAST =
    tatd_pkg::STEP_W'(tatd_pkg::CORDIC_ITERS - 1);
  localparam logic signed [AW-1:0] ROUND_HALF = AW'(1 << (tatd_pkg::ROUND_SH - 1));
  localparam logic signed [AW-1:0] LIM        = AW'(tatd_pkg::ANGLE_LIM);

  logic                          busy_q, fin_q, done_q, zero_q;
  logic [tatd_pkg::STEP_W-1:0]   step_q;
  logic signed [CW-1:0]          xc_q, yc_q;
  logic signed [AW-1:0]          z_q;
  logic signed [tatd_pkg::ANGLE_W-1:0] angle_q;

  logic signed [CW-1:0] dx, dy;
  logic signed [AW-1:0] atan_v, rounded, sat;

  // Shared shifter and adders for one vectoring step
  always_comb begin
    dx     = yc_q >>> step_q;
    dy     = xc_q >>> step_q;
    atan_v = signed'({{(AW - tatd_pkg::ATAN_W){1'b0}}, tatd_pkg::atan_entry(step_q)});
  end

  // Round half up to the output scale, clamp to +-90 degrees
  always_comb begin
    rounded = (z_q + ROUND_HALF) >>> tatd_pkg::ROUND_SH;
    if (rounded > LIM) begin
      sat = LIM;
    end else if (rounded < -LIM) begin
      sat = -LIM;
    end else begin
      sat = rounded;
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LAST) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        done_q <= 1'b1;
      end
    end
  end

  // Vectoring datapath: rotate towards the x axis, steering by the sign of y
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      xc_q   <= signed'({{(CW - tatd_pkg::ROOT_W - tatd_pkg::PRESCALE_SH){1'b0}}, den_i,
                         {tatd_pkg::PRESCALE_SH{1'b0}}});
      yc_q   <= signed'({{(CW - tatd_pkg::SAMPLE_W - tatd_pkg::PRESCALE_SH)
                            {num_i[tatd_pkg::SAMPLE_W-1]}},
                         num_i, {tatd_pkg::PRESCALE_SH{1'b0}}});
      z_q    <= '0;
      zero_q <= (num_i == '0) && (den_i == '0);
    end else if (busy_q) begin
      if (!yc_q[CW-1]) begin
        xc_q <= xc_q + dx;
        yc_q <= yc_q - dy;
        z_q  <= z_q + atan_v;
      end else begin
        xc_q <= xc_q - dx;
        yc_q <= yc_q + dy;
        z_q  <= z_q - atan_v;
      end
    end else if (fin_q) begin
      // null vector has no direction: report level
      angle_q <= zero_q ? '0 : sat[tatd_pkg::ANGLE_W-1:0];
    end
  end

  assign done_o  = done_q;
  assign angle_o = angle_q;

endmodule

FILE: rtl/tilt_angle_tipover_detector.sv
// Work per item, once its input beat is taken (CORDIC_STEPS = 16): squarings of
//   z, x and y on one shared multiplier, two 18-step square roots on the shared
//   root unit, two CORDIC_STEPS-step vectorings on the shared CORDIC, plus sequencing.
// Input is not ready while an item is in work; a finished result waits in the
//   output register while the next item is taken.
// Reset (async, active low): held x/y = 0, held z = 163840, axis counter on x,
//   limits at -3840/+3840, output empty.
module tilt_angle_tipover_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  tatd_in_if.sink     in_i,
  tatd_out_if.source  out_o,
  tatd_cfg_if.sink    cfg_i
);

  localparam int HW = tatd_pkg::HELD_W;
  localparam int SW = tatd_pkg::SAMPLE_W;

  // Sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQZ  = 4'd1;
  localparam logic [3:0] ST_SQX  = 4'd2;
  localparam logic [3:0] ST_SQY  = 4'd3;
  localparam logic [3:0] ST_SQS  = 4'd4;
  localparam logic [3:0] ST_MXG  = 4'd5;
  localparam logic [3:0] ST_MXW  = 4'd6;
  localparam logic [3:0] ST_MYG  = 4'd7;
  localparam logic [3:0] ST_MYW  = 4'd8;
  localparam logic [3:0] ST_AXG  = 4'd9;
  localparam logic [3:0] ST_AXW  = 4'd10;
  localparam logic [3:0] ST_AYG  = 4'd11;
  localparam logic [3:0] ST_AYW  = 4'd12;
  localparam logic [3:0] ST_DONE = 4'd13;

  logic [3:0] state_q, state_d;

  // Configuration and held state
  logic signed [tatd_pkg::CFG_DATA_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic signed [SW-1:0]                   held_x_q, held_y_q;
  logic signed [HW-1:0]                   held_z_q;
  logic [tatd_pkg::AXIS_W-1:0]            axis_cnt_q;

  // Working registers
  logic [tatd_pkg::AXIS_W-1:0]        cur_axis_q;
  logic signed [HW-1:0]               cur_val_q;
  logic [tatd_pkg::RAD_W-1:0]         sq_q, zz_q, rad_x_q, rad_y_q;
  logic [tatd_pkg::ROOT_W-1:0]        mag_x_q, mag_y_q;
  logic signed [tatd_pkg::ANGLE_W-1:0] ang_x_q, ang_y_q;

  // Output register
  logic                                out_valid_q;
  logic [tatd_pkg::AXIS_W-1:0]         out_axis_q;
  logic signed [HW-1:0]                out_val_q;
  logic signed [tatd_pkg::ANGLE_W-1:0] out_ax_q, out_ay_q;
  logic                                out_tip_q;

  logic in_acc, out_free, in_window;
  logic signed [HW-1:0] sq_op;
  logic signed [tatd_pkg::SQ_W-1:0] sq_full;
  logic signed [SW-1:0] new_x, new_y;
  logic signed [HW-1:0] new_z;

  logic                          sqrt_start, sqrt_done;
  logic [tatd_pkg::RAD_W-1:0]    sqrt_rad;
  logic [tatd_pkg::ROOT_W-1:0]   sqrt_root;
  logic                          cord_start, cord_done;
  logic signed [SW-1:0]          cord_num;
  logic [tatd_pkg::ROOT_W-1:0]   cord_den;
  logic signed [tatd_pkg::ANGLE_W-1:0] cord_angle;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_valid_q || out_o.ready;

  // Held values after this beat's update
  always_comb begin
    new_x = held_x_q;
    new_y = held_y_q;
    new_z = held_z_q;
    case (axis_cnt_q)
      tatd_pkg::AXIS_X: if (in_i.read_ok) new_x = in_i.raw_sample;
      tatd_pkg::AXIS_Y: if (in_i.read_ok) new_y = in_i.raw_sample;
      default:          if (in_i.read_ok) new_z = HW'(in_i.raw_sample);
    endcase
  end

  // Shared squaring multiplier
  always_comb begin
    case (state_q)
      ST_SQX:  sq_op = HW'(held_x_q);
      ST_SQY:  sq_op = HW'(held_y_q);
      default: sq_op = held_z_q;
    endcase
    sq_full = tatd_pkg::SQ_W'(sq_op) * tatd_pkg::SQ_W'(sq_op);
  end

  // Operand selection for the shared root and CORDIC units
  assign sqrt_start = (state_q == ST_MXG) || (state_q == ST_MYG);
  assign sqrt_rad   = (state_q == ST_MXG) ? rad_x_q : rad_y_q;
  assign cord_start = (state_q == ST_AXG) || (state_q == ST_AYG);
  assign cord_num   = (state_q == ST_AXG) ? held_y_q : held_x_q;
  assign cord_den   = (state_q == ST_AXG) ? mag_x_q : mag_y_q;

  tatd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_rad),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  tatd_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .num_i   (cord_num),
    .den_i   (cord_den),
    .done_o  (cord_done),
    .angle_o (cord_angle)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_SQZ;
      ST_SQZ:  state_d = ST_SQX;
      ST_SQX:  state_d = ST_SQY;
      ST_SQY:  state_d = ST_SQS;
      ST_SQS:  state_d = ST_MXG;
      ST_MXG:  state_d = ST_MXW;
      ST_MXW:  if (sqrt_done) state_d = ST_MYG;
      ST_MYG:  state_d = ST_MYW;
      ST_MYW:  if (sqrt_done) state_d = ST_AXG;
      ST_AXG:  state_d = ST_AXW;
      ST_AXW:  if (cord_done) state_d = ST_AYG;
      ST_AYG:  state_d = ST_AYW;
      ST_AYW:  if (cord_done) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Open window test on both angles
  assign in_window = (ang_x_q > min_x_q) && (ang_x_q < max_x_q) &&
                     (ang_y_q > min_y_q) && (ang_y_q < max_y_q);

  // Control state: sequencer, held values, limits, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_x_q    <= '0;
      held_y_q    <= '0;
      held_z_q    <= tatd_pkg::HELD_Z_RESET;
      axis_cnt_q  <= tatd_pkg::AXIS_X;
      min_x_q     <= tatd_pkg::MIN_RESET;
      max_x_q     <= tatd_pkg::MAX_RESET;
      min_y_q     <= tatd_pkg::MIN_RESET;
      max_y_q     <= tatd_pkg::MAX_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_i.valid) begin
        case (cfg_i.index)
          tatd_pkg::REG_MIN_X: min_x_q <= cfg_i.data;
          tatd_pkg::REG_MAX_X: max_x_q <= cfg_i.data;
          tatd_pkg::REG_MIN_Y: min_y_q <= cfg_i.data;
          tatd_pkg::REG_MAX_Y: max_y_q <= cfg_i.data;
          default: ;
        endcase
      end

      if (in_acc) begin
        held_x_q <= new_x;
        held_y_q <= new_y;
        held_z_q <= new_z;
        case (axis_cnt_q)
          tatd_pkg::AXIS_X: axis_cnt_q <= tatd_pkg::AXIS_Y;
          tatd_pkg::AXIS_Y: axis_cnt_q <= tatd_pkg::AXIS_Z;
          default:          axis_cnt_q <= tatd_pkg::AXIS_X;
        endcase
      end

      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      case (axis_cnt_q)
        tatd_pkg::AXIS_X: begin
          cur_axis_q <= tatd_pkg::AXIS_X;
          cur_val_q  <= HW'(new_x);
        end
        tatd_pkg::AXIS_Y: begin
          cur_axis_q <= tatd_pkg::AXIS_Y;
          cur_val_q  <= HW'(new_y);
        end
        default: begin
          cur_axis_q <= tatd_pkg::AXIS_Z;
          cur_val_q  <= new_z;
        end
      endcase
    end

    // squares are non-negative and below 2^35
    case (state_q)
      ST_SQZ: sq_q <= sq_full[tatd_pkg::RAD_W-1:0];
      ST_SQX: begin
        zz_q <= sq_q;
        sq_q <= sq_full[tatd_pkg::RAD_W-1:0];
      end
      ST_SQY: begin
        rad_x_q <= zz_q + sq_q;
        sq_q    <= sq_full[tatd_pkg::RAD_W-1:0];
      end
      ST_SQS: rad_y_q <= zz_q + sq_q;
      ST_MXW: if (sqrt_done) mag_x_q <= sqrt_root;
      ST_MYW: if (sqrt_done) mag_y_q <= sqrt_root;
      ST_AXW: if (cord_done) ang_x_q <= cord_angle;
      ST_AYW: if (cord_done) ang_y_q <= cord_angle;
      default: ;
    endcase

    if (state_q == ST_DONE && out_free) begin
      out_axis_q <= cur_axis_q;
      out_val_q  <= cur_val_q;
      out_ax_q   <= ang_x_q;
      out_ay_q   <= ang_y_q;
      out_tip_q  <= !in_window;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.axis       = out_axis_q;
  assign out_o.axis_value = out_val_q;
  assign out_o.angle_x    = out_ax_q;
  assign out_o.angle_y    = out_ay_q;
  assign out_o.tipped     = out_tip_q;

endmodule

FILE: rtl/tatd_checker.sv
module tatd_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic        [tatd_pkg::AXIS_W-1:0]  out_axis_i,
  input logic signed [tatd_pkg::HELD_W-1:0]  out_value_i,
  input logic signed [tatd_pkg::ANGLE_W-1:0] out_angle_x_i,
  input logic signed [tatd_pkg::ANGLE_W-1:0] out_angle_y_i,
  input logic                                out_tipped_i
);

  localparam logic signed [tatd_pkg::ANGLE_W-1:0] LIM = tatd_pkg::ANGLE_W'(tatd_pkg::ANGLE_LIM);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // An item keeps the input closed for the following cycles
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i ##1 !in_ready_i)
    else $error("input ready again right after a beat was accepted");

  // No result can rise in the cycle after an item is taken
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_i))
    else $error("result appeared too soon after input beat");

  // Angles saturate at +-90 degrees, axis is x, y or z
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_angle_x_i <= LIM) && (out_angle_x_i >= -LIM) &&
                    (out_angle_y_i <= LIM) && (out_angle_y_i >= -LIM) &&
                    (out_axis_i <= tatd_pkg::AXIS_Z))
    else $error("result beat out of range");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({out_axis_i, out_value_i, out_angle_x_i, out_angle_y_i, out_tipped_i}))
    else $error("stalled result beat changed");

endmodule

bind tilt_angle_tipover_detector tatd_checker u_tatd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_axis_i    (out_o.axis),
  .out_value_i   (out_o.axis_value),
  .out_angle_x_i (out_o.angle_x),
  .out_angle_y_i (out_o.angle_y),
  .out_tipped_i  (out_o.tipped)
);

FILE: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tatd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 200;
  localparam int LONG_HOLD_OFF = 600;
  localparam int RAND_PHASES   = 5;
  localparam int PHASE_ITEMS   = 100;

  localparam logic signed [CFG_DATA_W-1:0] LIM_MOST_NEG = {1'b1, {(CFG_DATA_W-1){1'b0}}};
  localparam logic signed [CFG_DATA_W-1:0] LIM_MOST_POS = {1'b0, {(CFG_DATA_W-1){1'b1}}};
  localparam logic signed [CFG_DATA_W-1:0] LIM_NEG_90   = CFG_DATA_W'(-ANGLE_LIM);
  localparam logic signed [CFG_DATA_W-1:0] LIM_POS_90   = CFG_DATA_W'(ANGLE_LIM);

  // atan(2^-i) in degrees scaled by 2^16
  localparam longint ATAN_DEG16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct {
    logic        [AXIS_W-1:0]  axis;
    logic signed [HELD_W-1:0]  axis_value;
    logic signed [ANGLE_W-1:0] angle_x;
    logic signed [ANGLE_W-1:0] angle_y;
    logic                      tipped;
  } tilt_result_t;

  logic clk_i;
  logic rst_ni;

  tatd_in_if  in_bus ();
  tatd_out_if out_bus ();
  tatd_cfg_if cfg_bus ();

  tilt_angle_tipover_detector DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  // Shadow state of the detector
  longint                       held_x, held_y, held_z;
  logic        [AXIS_W-1:0]     axis_sel;
  logic signed [CFG_DATA_W-1:0] lim_min_x, lim_max_x, lim_min_y, lim_max_y;

  tilt_result_t expected_tilt [$];
  int unsigned  mismatches    = 0;
  int unsigned  cycle_cnt     = 0;
  int unsigned  sink_hold_off = 0;
  bit           no_idle       = 1'b0;

  // Clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Floor square root, one result bit per pass
  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned root, trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return longint'(root);
  endfunction

  // Vectoring CORDIC: atan2(num, den) for den >= 0, degrees * 2^ANGLE_FRAC_BITS
  function automatic longint cordic_atan2_deg(longint num, longint den);
    longint xc, yc, acc, dx, dy, r;
    if (num == 0 && den == 0) return 0;
    xc  = den <<< PRESCALE_SH;
    yc  = num <<< PRESCALE_SH;
    acc = 0;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = yc >>> i;
      dy = xc >>> i;
      if (yc >= 0) begin
        xc  += dx;
        yc  -= dy;
        acc += ATAN_DEG16[i];
      end else begin
        xc  -= dx;
        yc  += dy;
        acc -= ATAN_DEG16[i];
      end
    end
    // round half up, then clamp to +-90 degrees
    r = (acc + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
    if (r > ANGLE_LIM) r = ANGLE_LIM;
    if (r < -ANGLE_LIM) r = -ANGLE_LIM;
    return r;
  endfunction

  // Update the shadow state with one reading and work out its result
  function automatic tilt_result_t predict_reading(logic signed [SAMPLE_W-1:0] raw, logic ok);
    tilt_result_t res;
    longint       sample, val, ax, ay;
    sample = raw;
    case (axis_sel)
      AXIS_X: begin
        if (ok) held_x = sample;
        val      = held_x;
        res.axis = AXIS_X;
        axis_sel = AXIS_Y;
      end
      AXIS_Y: begin
        if (ok) held_y = sample;
        val      = held_y;
        res.axis = AXIS_Y;
        axis_sel = AXIS_Z;
      end
      default: begin
        if (ok) held_z = sample;
        val      = held_z;
        res.axis = AXIS_Z;
        axis_sel = AXIS_X;
      end
    endcase
    ax = cordic_atan2_deg(held_y, floor_sqrt(held_x * held_x + held_z * held_z));
    ay = cordic_atan2_deg(held_x, floor_sqrt(held_y * held_y + held_z * held_z));
    res.axis_value = val[HELD_W-1:0];
    res.angle_x    = ax[ANGLE_W-1:0];
    res.angle_y    = ay[ANGLE_W-1:0];
    res.tipped     = !(ax > lim_min_x && ax < lim_max_x && ay > lim_min_y && ay < lim_max_y);
    return res;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    // mostly readings around one g, some full scale, some near zero
    if (pick < 6) return SAMPLE_W'(int'($urandom_range(0, 40000)) - 20000);
    if (pick < 8) return SAMPLE_W'($urandom());
    if (pick < 9) return SAMPLE_W'(int'($urandom_range(0, 128)) - 64);
    return '0;
  endfunction

  function automatic logic signed [CFG_DATA_W-1:0] draw_limit();
    return CFG_DATA_W'(int'($urandom_range(0, 2 * ANGLE_LIM)) - ANGLE_LIM);
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Send one reading beat; valid stays high afterwards for a back-to-back beat
  task automatic send_reading(input logic signed [SAMPLE_W-1:0] raw, input logic ok);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.raw_sample <= raw;
    in_bus.read_ok    <= ok;
    do @(posedge clk_i); while (!in_bus.ready);
    expected_tilt.push_back(predict_reading(raw, ok));
  endtask

  // Stop offering readings and wait for every outstanding result
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (expected_tilt.size() != 0) @(posedge clk_i);
  endtask

  // Write all four limit registers, one beat each
  task automatic set_limits(input logic signed [CFG_DATA_W-1:0] mn_x, mx_x, mn_y, mx_y);
    logic        [CFG_IDX_W-1:0]  idx [4];
    logic signed [CFG_DATA_W-1:0] val [4];
    idx = '{REG_MIN_X, REG_MAX_X, REG_MIN_Y, REG_MAX_Y};
    val = '{mn_x, mx_x, mn_y, mx_y};
    for (int k = 0; k < 4; k++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx[k];
      cfg_bus.data  <= val[k];
      do @(posedge clk_i); while (!cfg_bus.ready);
      case (idx[k])
        REG_MIN_X: lim_min_x = val[k];
        REG_MAX_X: lim_max_x = val[k];
        REG_MIN_Y: lim_min_y = val[k];
        default:   lim_max_y = val[k];
      endcase
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // Failed reads on every axis: reset values must show through
  task automatic test_reset_state();
    send_reading(16'sh7FFF, 1'b0);
    send_reading(16'sh8000, 1'b0);
    send_reading(16'sh1234, 1'b0);
  endtask

  // Full-scale counts, all-zero vector, zero magnitude under a nonzero numerator
  task automatic test_extreme_samples();
    send_reading(16'sh0000, 1'b1);
    send_reading(16'sh0000, 1'b1);
    send_reading(16'sh0000, 1'b1);
    send_reading(16'sh8000, 1'b1);
    send_reading(16'sh7FFF, 1'b1);
    send_reading(16'sh8000, 1'b1);
    send_reading(16'sh5555, 1'b0);
    send_reading(16'sh0000, 1'b1);
    send_reading(16'sh0000, 1'b1);
  endtask

  // Open bounds at +-90, out-of-range limits, inverted and empty windows
  task automatic test_limit_settings();
    drain_results();
    set_limits(LIM_NEG_90, LIM_POS_90, LIM_NEG_90, LIM_POS_90);
    send_reading(16'sh0000, 1'b1);
    send_reading(16'sd20000, 1'b1);
    send_reading(16'sh0000, 1'b1);
    drain_results();
    set_limits(LIM_MOST_NEG, LIM_MOST_POS, LIM_MOST_NEG, LIM_MOST_POS);
    send_reading(16'sh5555, 1'b1);
    send_reading(16'shAAAA, 1'b1);
    send_reading(16'sd16384, 1'b1);
    drain_results();
    set_limits(MAX_RESET, MIN_RESET, MAX_RESET, MIN_RESET);
    send_reading(16'sh0000, 1'b1);
    send_reading(16'sh0000, 1'b1);
    send_reading(16'sd16384, 1'b1);
    drain_results();
    set_limits('0, '0, '0, '0);
    send_reading(16'sh0000, 1'b1);
    send_reading(16'sh0000, 1'b1);
    send_reading(16'sd16384, 1'b1);
  endtask

  // Receiver holds off long enough for the block to fill and stall its input
  task automatic test_output_backpressure();
    drain_results();
    set_limits(MIN_RESET, MAX_RESET, MIN_RESET, MAX_RESET);
    sink_hold_off = LONG_HOLD_OFF;
    repeat (8) send_reading(draw_sample(), 1'b1);
  endtask

  // Random readings over several limit settings
  task automatic test_random_readings();
    logic signed [CFG_DATA_W-1:0] a_x, b_x, a_y, b_y;
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_results();
      if (p == 0) begin
        set_limits(MIN_RESET, MAX_RESET, MIN_RESET, MAX_RESET);
      end else begin
        a_x = draw_limit();
        b_x = draw_limit();
        a_y = draw_limit();
        b_y = draw_limit();
        // mostly ordered windows, now and then left as drawn
        if (a_x > b_x && $urandom_range(0, 7) != 0) {a_x, b_x} = {b_x, a_x};
        if (a_y > b_y && $urandom_range(0, 7) != 0) {a_y, b_y} = {b_y, a_y};
        set_limits(a_x, b_x, a_y, b_y);
      end
      no_idle = (p == 2);
      repeat (PHASE_ITEMS) send_reading(draw_sample(), $urandom_range(0, 9) != 0);
      no_idle = 1'b0;
    end
  endtask

  // Result receiver with random stalls and the occasional long hold-off
  initial begin : result_sink
    int unsigned stall;
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (sink_hold_off != 0) begin
        stall         = sink_hold_off;
        sink_hold_off = 0;
      end else if (no_idle) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 5);
      end
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : result_check
    tilt_result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_tilt.size() == 0) begin
        $error("result beat with no expectation pending");
        mismatches++;
      end else begin
        want = expected_tilt.pop_front();
        check_field("axis", want.axis, out_bus.axis);
        check_field("axis_value", want.axis_value, out_bus.axis_value);
        check_field("angle_x", want.angle_x, out_bus.angle_x);
        check_field("angle_y", want.angle_y, out_bus.angle_y);
        check_field("tipped", want.tipped, out_bus.tipped);
      end
    end
  end

  // Test sequence
  initial begin
    in_bus.valid      <= 1'b0;
    in_bus.raw_sample <= '0;
    in_bus.read_ok    <= 1'b0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= REG_MIN_X;
    cfg_bus.data      <= '0;
    rst_ni            <= 1'b0;
    held_x    = 0;
    held_y    = 0;
    held_z    = HELD_Z_RESET;
    axis_sel  = AXIS_X;
    lim_min_x = MIN_RESET;
    lim_max_x = MAX_RESET;
    lim_min_y = MIN_RESET;
    lim_max_y = MAX_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_extreme_samples();
    test_limit_settings();
    test_output_backpressure();
    test_random_readings();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_tilt.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tatd_pkg.sv
rtl/tatd_in_if.sv
rtl/tatd_out_if.sv
rtl/tatd_cfg_if.sv
rtl/tatd_sqrt.sv
rtl/tatd_cordic.sv
rtl/tilt_angle_tipover_detector.sv
rtl/tatd_checker.sv
dv/tb_top.sv
